[rtl/sph_density_pressure_accumulator_assert.svh]
// assertion macros shared by the density accumulator modules
`ifndef SPH_DENSITY_PRESSURE_ACCUMULATOR_ASSERT_SVH
`define SPH_DENSITY_PRESSURE_ACCUMULATOR_ASSERT_SVH
`ifndef SYNTH
`define SPHDPA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sphdpa assertion failed");
`define SPHDPA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sphdpa assertion failed");
`else
`define SPHDPA_ASSERT_IMP(lbl, ante, cons)
`define SPHDPA_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[rtl/sphdpa_pkg.sv]
// shared types and constants of the sph density and pressure accumulator
package sphdpa_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned CFG_IDX_W   = 3;

    localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING_SQ = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_COEFF = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DENSITY  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STIFFNESS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REST_DENSITY = 3'd4;

    // reset values, unsigned q16.16
    localparam logic [31:0] RST_SMOOTHING_SQ = 32'd65536;
    localparam logic [31:0] RST_KERNEL_COEFF = 32'd102694;
    localparam logic [31:0] RST_MIN_DENSITY  = 32'd655360;
    localparam logic [31:0] RST_STIFFNESS    = 32'd45875;
    localparam logic [31:0] RST_REST_DENSITY = 32'd655360;

    typedef struct packed {
        logic signed [31:0] self_x;
        logic signed [31:0] self_y;
        logic signed [31:0] self_z;
        logic signed [31:0] nbr_x;
        logic signed [31:0] nbr_y;
        logic signed [31:0] nbr_z;
        logic [31:0]        nbr_mass;
        logic               last_nbr;
    } t_pair;

    typedef struct packed {
        logic [31:0]        density_out;
        logic signed [31:0] pressure_out;
    } t_result;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [31:0]          value;
    } t_cfg_wr;

    typedef struct packed {
        logic [31:0] smoothing_sq;
        logic [31:0] kernel_coeff;
        logic [31:0] min_density;
        logic [31:0] stiffness;
        logic [31:0] rest_density;
    } t_cfg_regs;

    // classified pair handed from the front to the back
    typedef struct packed {
        logic [31:0] q;
        logic        hit;
        logic [31:0] mass;
        logic        last;
    } t_work;

endpackage

[rtl/sphdpa_stream_if.sv]
// valid/ready channel carrying one word of a given type
interface sphdpa_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/sphdpa_front.sv]
// front pipeline: coordinate differences, squared distance, radius test and margin
module sphdpa_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [31:0]           i_smoothing_sq,
    sphdpa_stream_if.sink         i_pair,
    sphdpa_stream_if.source       o_work
);
    import sphdpa_pkg::*;

    localparam logic [32:0] FAR_LIMIT = 33'h1000000;

    function automatic logic [32:0] f_abs_diff(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] d;
        d = {a[31], a} - {b[31], b};
        return d[32] ? (~d + 33'd1) : d;
    endfunction

    logic        w_adv;
    logic [32:0] w_ax, w_ay, w_az;
    logic [50:0] w_h2;
    logic [50:0] w_margin;
    logic        w_hit;

    logic        r1_valid, r1_far, r1_last;
    logic [24:0] r1_dx, r1_dy, r1_dz;
    logic [31:0] r1_mass;

    logic        r2_valid, r2_far, r2_last;
    logic [48:0] r2_sx, r2_sy, r2_sz;
    logic [31:0] r2_mass;

    logic        r3_valid, r3_far, r3_last;
    logic [50:0] r3_r2;
    logic [31:0] r3_mass;

    // stages move together whenever the output stage can drain
    assign w_adv        = !r3_valid || o_work.ready;
    assign i_pair.ready = w_adv;

    assign w_ax = f_abs_diff(i_pair.data.self_x, i_pair.data.nbr_x);
    assign w_ay = f_abs_diff(i_pair.data.self_y, i_pair.data.nbr_y);
    assign w_az = f_abs_diff(i_pair.data.self_z, i_pair.data.nbr_z);

    assign w_h2     = {3'b000, i_smoothing_sq, 16'h0000};
    assign w_margin = w_h2 - r3_r2;
    assign w_hit    = !r3_far && (r3_r2 < w_h2);

    assign o_work.valid     = r3_valid;
    assign o_work.data.q    = w_margin[47:16];
    assign o_work.data.hit  = w_hit;
    assign o_work.data.mass = r3_mass;
    assign o_work.data.last = r3_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else if (w_adv) begin
            r1_valid <= i_pair.valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_far  <= (w_ax > FAR_LIMIT) || (w_ay > FAR_LIMIT) || (w_az > FAR_LIMIT);
            r1_dx   <= w_ax[24:0];
            r1_dy   <= w_ay[24:0];
            r1_dz   <= w_az[24:0];
            r1_mass <= i_pair.data.nbr_mass;
            r1_last <= i_pair.data.last_nbr;

            r2_far  <= r1_far;
            r2_sx   <= 49'(r1_dx) * 49'(r1_dx);
            r2_sy   <= 49'(r1_dy) * 49'(r1_dy);
            r2_sz   <= 49'(r1_dz) * 49'(r1_dz);
            r2_mass <= r1_mass;
            r2_last <= r1_last;

            r3_far  <= r2_far;
            r3_r2   <= 51'(r2_sx) + 51'(r2_sy) + 51'(r2_sz);
            r3_mass <= r2_mass;
            r3_last <= r2_last;
        end
    end

endmodule

[rtl/sphdpa_queue.sv]
// short first-in first-out queue between front and back
`include "sph_density_pressure_accumulator_assert.svh"
module sphdpa_queue #(
    parameter int unsigned DEPTH = sphdpa_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    sphdpa_stream_if.sink   i_work,
    sphdpa_stream_if.source o_work
);
    import sphdpa_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_work            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push, w_pop;

    assign i_work.ready = (r_count != FULL_CNT);
    assign o_work.valid = (r_count != '0);
    assign o_work.data  = r_mem[r_rd_ptr];

    assign w_push = i_work.valid && i_work.ready;
    assign w_pop  = o_work.valid && o_work.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_work.data;
        end
    end

    `SPHDPA_ASSERT_NXT(a_count_up, w_push && !w_pop, r_count == $past(r_count) + CNT_W'(1))
    `SPHDPA_ASSERT_NXT(a_count_down, w_pop && !w_push, r_count == $past(r_count) - CNT_W'(1))

endmodule

[rtl/sphdpa_back.sv]
// back end: kernel terms on a shared multiplier, saturating sum, density and pressure
`include "sph_density_pressure_accumulator_assert.svh"
module sphdpa_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sphdpa_pkg::t_cfg_regs i_cfg_regs,
    sphdpa_stream_if.sink         i_work,
    sphdpa_stream_if.source       o_result
);
    import sphdpa_pkg::*;

    localparam logic [47:0] SAT48 = 48'hFFFF_FFFF_FFFF;

    typedef enum logic [15:0] {
        ST_IDLE = 16'h0001,
        ST_SQ   = 16'h0002,
        ST_K    = 16'h0004,
        ST_C0   = 16'h0008,
        ST_C1   = 16'h0010,
        ST_C2   = 16'h0020,
        ST_C3   = 16'h0040,
        ST_T0   = 16'h0080,
        ST_T1   = 16'h0100,
        ST_T2   = 16'h0200,
        ST_T3   = 16'h0400,
        ST_T4   = 16'h0800,
        ST_ADD  = 16'h1000,
        ST_FIN  = 16'h2000,
        ST_PR0  = 16'h4000,
        ST_PR1  = 16'h8000
    } t_state;

    t_state      r_state, n_state;
    logic [31:0] r_q, r_mass;
    logic        r_last;
    logic [63:0] r_prod;
    logic [47:0] r_sq, r_k, r_cube, r_sum;
    logic [95:0] r_acc;
    logic [31:0] r_dens;
    logic        r_neg;
    t_result     r_out;
    logic        r_out_valid;

    logic        w_pop, w_out_free;
    logic        w_mul_en;
    logic [31:0] w_mul_a, w_mul_b;
    logic [63:0] w_prod;
    logic [47:0] w_sat_acc;
    logic [48:0] w_sum_ext;
    logic [47:0] w_sum_sat;
    logic [31:0] w_dens_sat, w_dens_clamp;
    logic        w_below_rest;
    logic [31:0] w_mag;
    logic [47:0] w_pmag;
    logic [31:0] w_press;

    assign i_work.ready   = (r_state == ST_IDLE);
    assign w_pop          = i_work.valid && i_work.ready;
    assign w_out_free     = !r_out_valid || o_result.ready;
    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out;

    // operand select for the one 32x32 multiplier
    always_comb begin
        w_mul_en = 1'b1;
        w_mul_a  = '0;
        w_mul_b  = '0;
        unique case (r_state)
            ST_SQ: begin
                w_mul_a = r_q;
                w_mul_b = r_q;
            end
            ST_K: begin
                w_mul_a = r_mass;
                w_mul_b = i_cfg_regs.kernel_coeff;
            end
            ST_C0: begin
                w_mul_a = r_sq[31:0];
                w_mul_b = r_q;
            end
            ST_C1: begin
                w_mul_a = {16'h0000, r_sq[47:32]};
                w_mul_b = r_q;
            end
            ST_T0: begin
                w_mul_a = r_k[31:0];
                w_mul_b = r_cube[31:0];
            end
            ST_T1: begin
                w_mul_a = r_k[31:0];
                w_mul_b = {16'h0000, r_cube[47:32]};
            end
            ST_T2: begin
                w_mul_a = {16'h0000, r_k[47:32]};
                w_mul_b = r_cube[31:0];
            end
            ST_T3: begin
                w_mul_a = {16'h0000, r_k[47:32]};
                w_mul_b = {16'h0000, r_cube[47:32]};
            end
            ST_PR0: begin
                w_mul_a = w_mag;
                w_mul_b = i_cfg_regs.stiffness;
            end
            default: begin
                w_mul_en = 1'b0;
            end
        endcase
    end

    assign w_prod = 64'(w_mul_a) * 64'(w_mul_b);

    // q16.16 truncation of the wide product, saturated to 48 bits
    assign w_sat_acc = (r_acc[95:64] != '0) ? SAT48 : r_acc[63:16];
    assign w_sum_ext = {1'b0, r_sum} + {1'b0, w_sat_acc};
    assign w_sum_sat = w_sum_ext[48] ? SAT48 : w_sum_ext[47:0];

    assign w_dens_sat   = (r_sum[47:32] != '0) ? 32'hFFFF_FFFF : r_sum[31:0];
    assign w_dens_clamp = (w_dens_sat < i_cfg_regs.min_density) ? i_cfg_regs.min_density
                                                                  : w_dens_sat;

    assign w_below_rest = r_dens < i_cfg_regs.rest_density;
    assign w_mag        = w_below_rest ? (i_cfg_regs.rest_density - r_dens)
                                       : (r_dens - i_cfg_regs.rest_density);

    assign w_pmag = r_prod[63:16];
    always_comb begin
        if (r_neg) begin
            w_press = (w_pmag > 48'h0000_8000_0000) ? 32'h8000_0000
                                                     : (~w_pmag[31:0] + 32'd1);
        end else begin
            w_press = (w_pmag > 48'h0000_7FFF_FFFF) ? 32'h7FFF_FFFF : w_pmag[31:0];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_work.valid) begin
                    if (i_work.data.hit) begin
                        n_state = ST_SQ;
                    end else if (i_work.data.last) begin
                        n_state = ST_FIN;
                    end
                end
            end
            ST_SQ:  n_state = ST_K;
            ST_K:   n_state = ST_C0;
            ST_C0:  n_state = ST_C1;
            ST_C1:  n_state = ST_C2;
            ST_C2:  n_state = ST_C3;
            ST_C3:  n_state = ST_T0;
            ST_T0:  n_state = ST_T1;
            ST_T1:  n_state = ST_T2;
            ST_T2:  n_state = ST_T3;
            ST_T3:  n_state = ST_T4;
            ST_T4:  n_state = ST_ADD;
            ST_ADD: n_state = r_last ? ST_FIN : ST_IDLE;
            ST_FIN: n_state = ST_PR0;
            ST_PR0: n_state = ST_PR1;
            ST_PR1: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_ADD) begin
                r_sum <= w_sum_sat;
            end else if (r_state == ST_FIN) begin
                r_sum <= '0;
            end
            if (r_state == ST_PR1 && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_q    <= i_work.data.q;
            r_mass <= i_work.data.mass;
            r_last <= i_work.data.last;
        end
        if (w_mul_en) begin
            r_prod <= w_prod;
        end
        case (r_state)
            ST_K:   r_sq   <= r_prod[63:16];
            ST_C0:  r_k    <= r_prod[63:16];
            ST_C1:  r_acc  <= {32'h0, r_prod};
            ST_C2:  r_acc  <= r_acc + {r_prod, 32'h0};
            ST_C3:  r_cube <= w_sat_acc;
            ST_T1:  r_acc  <= {32'h0, r_prod};
            ST_T2:  r_acc  <= r_acc + {r_prod, 32'h0};
            ST_T3:  r_acc  <= r_acc + {r_prod, 32'h0};
            ST_T4:  r_acc  <= r_acc + {r_prod[31:0], 64'h0};
            ST_FIN: r_dens <= w_dens_clamp;
            ST_PR0: r_neg  <= w_below_rest;
            ST_PR1: begin
                if (w_out_free) begin
                    r_out.density_out  <= r_dens;
                    r_out.pressure_out <= w_press;
                end
            end
            default: begin
            end
        endcase
    end

    `SPHDPA_ASSERT_NXT(a_sum_cleared, r_state == ST_FIN, r_sum == '0)
    `SPHDPA_ASSERT_NXT(a_sum_grows, r_state == ST_ADD, r_sum >= $past(r_sum))
    `SPHDPA_ASSERT_NXT(a_result_held, r_state == ST_PR1 && r_out_valid && !o_result.ready,
                       r_state == ST_PR1)

endmodule

[rtl/sph_density_pressure_accumulator.sv]
// top level of the sph poly6 density and pressure accumulator
// Takes one particle-neighbour word per cycle, unless a full queue stalls the front,
// into a three-stage front pipeline (absolute differences, squared distance, radius
// test) that feeds a queue of QUEUE_DEPTH classified pairs. The back end works one
// pair at a time on a single shared 32x32 multiplier: a pair inside the smoothing
// radius runs the square, kernel, cube and term states and the add, a pair at or
// beyond it is taken in the idle state, and a word marked last_nbr then runs the
// states for the density clamp and pressure product before the result is loaded
// into the output register. The back end takes no new pair until it is done with
// the last, so its multiplier sequence sets the sustained rate. Configuration writes
// are taken in any cycle and must only be issued while the block is idle.
module sph_density_pressure_accumulator #(
    parameter int unsigned QUEUE_DEPTH = sphdpa_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    sphdpa_stream_if.sink   i_pair,
    sphdpa_stream_if.sink   i_cfg,
    sphdpa_stream_if.source o_result
);
    import sphdpa_pkg::*;

    t_cfg_regs r_cfg;

    sphdpa_stream_if #(.T(t_work)) w_front_q ();
    sphdpa_stream_if #(.T(t_work)) w_q_back ();

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.smoothing_sq <= RST_SMOOTHING_SQ;
            r_cfg.kernel_coeff <= RST_KERNEL_COEFF;
            r_cfg.min_density  <= RST_MIN_DENSITY;
            r_cfg.stiffness    <= RST_STIFFNESS;
            r_cfg.rest_density <= RST_REST_DENSITY;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.data.index)
                REG_SMOOTHING_SQ: r_cfg.smoothing_sq <= i_cfg.data.value;
                REG_KERNEL_COEFF: r_cfg.kernel_coeff <= i_cfg.data.value;
                REG_MIN_DENSITY:  r_cfg.min_density  <= i_cfg.data.value;
                REG_STIFFNESS:    r_cfg.stiffness    <= i_cfg.data.value;
                REG_REST_DENSITY: r_cfg.rest_density <= i_cfg.data.value;
                default: begin
                end
            endcase
        end
    end

    sphdpa_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_smoothing_sq (r_cfg.smoothing_sq),
        .i_pair         (i_pair),
        .o_work         (w_front_q)
    );

    sphdpa_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_work  (w_front_q),
        .o_work  (w_q_back)
    );

    sphdpa_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_regs (r_cfg),
        .i_work     (w_q_back),
        .o_result   (o_result)
    );

endmodule
